/* sv/hcas_pkg.sv */
// Shared types and constants for the hold-to-confirm arm sequencer.
// No dependencies; used by hcas_ctrl, hcas_dp and the top level.
package hcas_pkg;

  // Sequence states as reported on the result channel
  typedef enum logic [2:0] {
    SEQ_READY     = 3'd0,
    SEQ_BLOCKED   = 3'd1,
    SEQ_HOLD      = 3'd2,
    SEQ_COUNTDOWN = 3'd3,
    SEQ_ARMING    = 3'd4,
    SEQ_FAILED    = 3'd5,
    SEQ_SETMODE   = 3'd6,
    SEQ_MOVING    = 3'd7
  } seq_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_HOLD_TIME      = 2'd0,
    REG_COUNTDOWN_TIME = 2'd1,
    REG_ARM_TIMEOUT    = 2'd2,
    REG_AUTO_MODE      = 2'd3
  } cfg_reg_t;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [15:0] HoldTimeRst      = 16'd2000;
  localparam logic [15:0] CountdownTimeRst = 16'd5000;
  localparam logic [15:0] ArmTimeoutRst    = 16'd3000;
  localparam logic [7:0]  AutoModeRst      = 8'd10;

  // Quotient of the serial divider: hold permille below 1000
  localparam int DivSteps  = 10;
  localparam int DivCntW   = $clog2(DivSteps);
  localparam int DivDendW  = 26;
  localparam int DivSorW   = 16;

  localparam logic [9:0]  PermilleFull = 10'd1000;
  localparam logic [9:0]  PermilleMul  = 10'd1000;
  localparam logic [16:0] RoundUpMs    = 17'd999;

  // Seconds: x / 1000 as (x * SecRecip) >> SecShift, exact for any 17-bit x
  localparam logic [16:0] SecRecip = 17'd67109;
  localparam int          SecShift = 26;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the accepted item
    logic step;      // advance the sequence state
    logic prep;      // set up the result or the divider
    logic div_step;  // one restoring division step
    logic out_load;  // fill the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;
  } dp_sts_t;

endpackage

/* sv/hold_confirm_arm_sequencer.sv */
// Hold-to-confirm arm sequencer, top level: hcas_ctrl plus hcas_dp.
// The result is registered through the step, prepare and done states, and
// through the 10-step permille divider as well for a hold with partial progress.
// Input stalls until the controller is back in idle, and output stall holds it in done;
// an item is taken while the previous result still waits in the output register.
// Reset: synchronous, active low; restores register defaults, ready state.
module hold_confirm_arm_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hcas_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [hcas_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   in_now_ms,
  input  logic                          in_active,
  input  logic                          in_btn_press,
  input  logic                          in_btn_down,
  input  logic                          in_route_loaded,
  input  logic                          in_heartbeat_seen,
  input  logic                          in_vehicle_armed,
  input  logic [7:0]                    in_vehicle_mode,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_send_arm,
  output logic                          out_send_mode_auto,
  output logic [2:0]                    out_sequence_state,
  output logic [9:0]                    out_hold_permille,
  output logic [6:0]                    out_countdown_seconds
);

  hcas_pkg::dp_cmd_t cmd;
  hcas_pkg::dp_sts_t sts;

  hcas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  hcas_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_now_ms             (in_now_ms),
    .in_active             (in_active),
    .in_btn_press          (in_btn_press),
    .in_btn_down           (in_btn_down),
    .in_route_loaded       (in_route_loaded),
    .in_heartbeat_seen     (in_heartbeat_seen),
    .in_vehicle_armed      (in_vehicle_armed),
    .in_vehicle_mode       (in_vehicle_mode),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_send_arm          (out_send_arm),
    .out_send_mode_auto    (out_send_mode_auto),
    .out_sequence_state    (out_sequence_state),
    .out_hold_permille     (out_hold_permille),
    .out_countdown_seconds (out_countdown_seconds)
  );

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("output register loaded but no valid result");

  a_arm_in_arming: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_send_arm) |-> (out_sequence_state == hcas_pkg::SEQ_ARMING))
    else $error("arm command outside the arming state");

  a_mode_in_setmode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_send_mode_auto) |-> (out_sequence_state == hcas_pkg::SEQ_SETMODE))
    else $error("mode command outside the setting mode state");

  a_permille_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_hold_permille <= hcas_pkg::PermilleFull) &&
                   ((out_sequence_state == hcas_pkg::SEQ_HOLD) ||
                    (out_hold_permille == '0))))
    else $error("hold progress out of range or outside hold");

endmodule

/* sv/hcas_ctrl.sv */
// Controller of the arm sequencer: item handshake, step sequencing and
// divider step count. Depends on hcas_pkg; drives hcas_dp through dp_cmd_t.
module hcas_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  hcas_pkg::dp_sts_t sts,
  output hcas_pkg::dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_STEP = 5'b00010,
    C_PREP = 5'b00100,
    C_DIV  = 5'b01000,
    C_DONE = 5'b10000
  } ctrl_state_t;

  ctrl_state_t                   state_r, state_nxt;
  logic [hcas_pkg::DivCntW-1:0]  cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != C_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      C_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = C_STEP;
        end
      end
      C_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = C_PREP;
      end
      C_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.need_div ? C_DIV : C_DONE;
      end
      C_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == hcas_pkg::DivCntW'(hcas_pkg::DivSteps - 1)) begin
          state_nxt = C_DONE;
        end
      end
      C_DONE: begin
        // hold until the previous result is taken
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = C_IDLE;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/hcas_dp.sv */
// Datapath of the arm sequencer: config registers, sequence state, elapsed
// time, permille divider, seconds reciprocal and output register. Depends on hcas_pkg.
module hcas_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hcas_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [hcas_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic [31:0]                   in_now_ms,
  input  logic                          in_active,
  input  logic                          in_btn_press,
  input  logic                          in_btn_down,
  input  logic                          in_route_loaded,
  input  logic                          in_heartbeat_seen,
  input  logic                          in_vehicle_armed,
  input  logic [7:0]                    in_vehicle_mode,
  input  hcas_pkg::dp_cmd_t             cmd,
  output hcas_pkg::dp_sts_t             sts,
  output logic                          out_send_arm,
  output logic                          out_send_mode_auto,
  output logic [2:0]                    out_sequence_state,
  output logic [9:0]                    out_hold_permille,
  output logic [6:0]                    out_countdown_seconds
);

  // configuration
  logic [15:0] hold_r, cd_r, tmo_r;
  logic [7:0]  auto_r;

  // captured item
  logic [31:0] now_r;
  logic        active_r, pressed_r, held_r, route_r, hb_r, armed_r;
  logic [7:0]  mode_r;

  // sequence state
  hcas_pkg::seq_t seq_r, seq_nxt;
  logic [31:0]    ent_r, ent_nxt;
  logic           arm_r, arm_nxt, mcmd_r, mcmd_nxt;
  logic [31:0]    el_r;
  logic [31:0]    elapsed;

  // divider
  logic [hcas_pkg::DivSorW-1:0]   rem_r, sor_r;
  logic [hcas_pkg::DivSteps-1:0]  low_r, q_r;
  logic [9:0]                     direct_r;
  logic                           use_q_r;

  logic [hcas_pkg::DivDendW-1:0]  dend_c;
  logic [hcas_pkg::DivSorW-1:0]   sor_c;
  logic [9:0]                     direct_c;
  logic                           need_div_c;
  logic [hcas_pkg::DivDendW-1:0]  prod;
  logic [16:0]                    cd_sum;
  logic [33:0]                    cd_prod;
  logic [hcas_pkg::DivSorW:0]     trial;
  logic [hcas_pkg::DivSorW:0]     diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= hcas_pkg::HoldTimeRst;
      cd_r   <= hcas_pkg::CountdownTimeRst;
      tmo_r  <= hcas_pkg::ArmTimeoutRst;
      auto_r <= hcas_pkg::AutoModeRst;
    end else if (cfg_we) begin
      case (cfg_index)
        hcas_pkg::REG_HOLD_TIME:      hold_r <= cfg_wdata;
        hcas_pkg::REG_COUNTDOWN_TIME: cd_r   <= cfg_wdata;
        hcas_pkg::REG_ARM_TIMEOUT:    tmo_r  <= cfg_wdata;
        hcas_pkg::REG_AUTO_MODE:      auto_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r     <= in_now_ms;
      active_r  <= in_active;
      pressed_r <= in_btn_press;
      held_r    <= in_btn_down;
      route_r   <= in_route_loaded;
      hb_r      <= in_heartbeat_seen;
      armed_r   <= in_vehicle_armed;
      mode_r    <= in_vehicle_mode;
    end
  end

  assign elapsed = now_r - ent_r;

  always_comb begin
    seq_nxt  = seq_r;
    ent_nxt  = ent_r;
    arm_nxt  = 1'b0;
    mcmd_nxt = 1'b0;
    if (!active_r) begin
      // drop to ready, keep the entry time
      seq_nxt = hcas_pkg::SEQ_READY;
    end else begin
      case (seq_r)
        hcas_pkg::SEQ_READY, hcas_pkg::SEQ_BLOCKED: begin
          seq_nxt = route_r ? hcas_pkg::SEQ_READY : hcas_pkg::SEQ_BLOCKED;
          if (pressed_r && route_r) begin
            seq_nxt = hcas_pkg::SEQ_HOLD;
            ent_nxt = now_r;
          end
        end
        hcas_pkg::SEQ_HOLD: begin
          if (!held_r) begin
            seq_nxt = hcas_pkg::SEQ_READY;
            ent_nxt = now_r;
          end else if (elapsed >= {16'd0, hold_r}) begin
            seq_nxt = hcas_pkg::SEQ_COUNTDOWN;
            ent_nxt = now_r;
          end
        end
        hcas_pkg::SEQ_COUNTDOWN: begin
          if (elapsed >= {16'd0, cd_r}) begin
            arm_nxt = 1'b1;
            seq_nxt = hcas_pkg::SEQ_ARMING;
            ent_nxt = now_r;
          end
        end
        hcas_pkg::SEQ_FAILED: begin
          if (pressed_r && route_r) begin
            seq_nxt = hcas_pkg::SEQ_HOLD;
            ent_nxt = now_r;
          end
        end
        hcas_pkg::SEQ_ARMING: begin
          if (hb_r && armed_r) begin
            mcmd_nxt = 1'b1;
            seq_nxt  = hcas_pkg::SEQ_SETMODE;
            ent_nxt  = now_r;
          end else if (elapsed > {16'd0, tmo_r}) begin
            seq_nxt = hcas_pkg::SEQ_FAILED;
            ent_nxt = now_r;
          end
        end
        hcas_pkg::SEQ_SETMODE: begin
          if (hb_r && (mode_r == auto_r)) begin
            seq_nxt = hcas_pkg::SEQ_MOVING;
            ent_nxt = now_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= hcas_pkg::SEQ_READY;
      ent_r <= '0;
    end else if (cmd.step) begin
      seq_r <= seq_nxt;
      ent_r <= ent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      arm_r  <= arm_nxt;
      mcmd_r <= mcmd_nxt;
      el_r   <= now_r - ent_nxt;
    end
  end

  // Hold: elapsed below hold time keeps elapsed*1000 under 26 bits.
  // Countdown: ceil of remaining ms over 1000, by reciprocal multiply.
  assign prod    = hcas_pkg::DivDendW'(el_r[15:0]) *
                   hcas_pkg::DivDendW'(hcas_pkg::PermilleMul);
  assign cd_sum  = {1'b0, cd_r} - {1'b0, el_r[15:0]} + hcas_pkg::RoundUpMs;
  assign cd_prod = 34'(cd_sum) * 34'(hcas_pkg::SecRecip);

  always_comb begin
    dend_c     = '0;
    sor_c      = hold_r;
    direct_c   = '0;
    need_div_c = 1'b0;
    case (seq_r)
      hcas_pkg::SEQ_HOLD: begin
        if (el_r == '0) begin
          direct_c = '0;
        end else if ((hold_r == '0) || (el_r >= {16'd0, hold_r})) begin
          direct_c = hcas_pkg::PermilleFull;
        end else begin
          need_div_c = 1'b1;
          dend_c     = prod;
          sor_c      = hold_r;
        end
      end
      hcas_pkg::SEQ_COUNTDOWN: begin
        if (el_r < {16'd0, cd_r}) begin
          direct_c = {3'd0, cd_prod[hcas_pkg::SecShift +: 7]};
        end
      end
      default: ;
    endcase
  end

  assign sts.need_div = need_div_c;

  // Restoring division; the quotient fits DivSteps bits, so the upper
  // dividend bits already sit below the divisor.
  assign trial = {rem_r, low_r[hcas_pkg::DivSteps-1]};
  assign diff  = trial - {1'b0, sor_r};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rem_r    <= dend_c[hcas_pkg::DivDendW-1:hcas_pkg::DivSteps];
      low_r    <= dend_c[hcas_pkg::DivSteps-1:0];
      sor_r    <= sor_c;
      q_r      <= '0;
      direct_r <= direct_c;
      use_q_r  <= need_div_c;
    end else if (cmd.div_step) begin
      low_r <= {low_r[hcas_pkg::DivSteps-2:0], 1'b0};
      if (trial >= {1'b0, sor_r}) begin
        rem_r <= diff[hcas_pkg::DivSorW-1:0];
        q_r   <= {q_r[hcas_pkg::DivSteps-2:0], 1'b1};
      end else begin
        rem_r <= trial[hcas_pkg::DivSorW-1:0];
        q_r   <= {q_r[hcas_pkg::DivSteps-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_send_arm       <= arm_r;
      out_send_mode_auto <= mcmd_r;
      out_sequence_state <= seq_r;
      if (seq_r == hcas_pkg::SEQ_HOLD) begin
        out_hold_permille <= use_q_r ? q_r : direct_r;
      end else begin
        out_hold_permille <= '0;
      end
      if (seq_r == hcas_pkg::SEQ_COUNTDOWN) begin
        out_countdown_seconds <= direct_r[6:0];
      end else begin
        out_countdown_seconds <= '0;
      end
    end
  end

endmodule
